// ----- design/icd_pkg.sv -----
// ----------------------------------------------------------------------------
// icd_pkg
// Shared types, constants and helper functions of the invisible code point
// detector: byte classification, queue item layout and the code point list.
// ----------------------------------------------------------------------------
package icd_pkg;

   localparam int unsigned ByteW      = 8;
   localparam int unsigned DataW      = 8;
   localparam int unsigned CpW        = 21;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned PendDepth  = 3;
   localparam int unsigned WinDepth   = 7;

   // Sequence length announced by a byte; zero means the byte is skipped alone
   typedef logic [2:0] seq_len_type;

   localparam seq_len_type LenSkip = 3'd0;
   localparam seq_len_type LenOne  = 3'd1;
   localparam seq_len_type Len2    = 3'd2;
   localparam seq_len_type Len3    = 3'd3;
   localparam seq_len_type Len4    = 3'd4;

   typedef logic [CpW-1:0] cp_type;

   // Listed invisible and direction-changing code points
   localparam cp_type ZwspLo   = 21'h0200B;
   localparam cp_type ZwspHi   = 21'h0200D;
   localparam cp_type Bom      = 21'h0FEFF;
   localparam cp_type BidiLo   = 21'h0202A;
   localparam cp_type BidiHi   = 21'h0202E;
   localparam cp_type IsoLo    = 21'h02066;
   localparam cp_type IsoHi    = 21'h02069;
   localparam cp_type HangFill = 21'h03164;
   localparam cp_type ChoFill  = 21'h0115F;
   localparam cp_type JungFill = 21'h01160;
   localparam cp_type HalfFill = 21'h0FFA0;
   localparam cp_type SoftHyph = 21'h000AD;
   localparam cp_type Cgj      = 21'h0034F;
   localparam cp_type ArabMark = 21'h0061C;
   localparam cp_type MongSep  = 21'h0180E;

   // One classified text byte
   typedef struct packed {
      logic [ByteW-1:0] data;
      seq_len_type      len;
      logic             cont;
   } sym_type;

   // One queue entry: a classified byte and its end-of-text mark
   typedef struct packed {
      sym_type sym;
      logic    last;
   } item_type;

   function automatic seq_len_type lead_length(logic [ByteW-1:0] b);
      seq_len_type len;
      len = LenSkip;
      if (b[7:5] == 3'b110) begin
         len = Len2;
      end else if (b[7:4] == 4'b1110) begin
         len = Len3;
      end else if (b[7:3] == 5'b11110) begin
         len = Len4;
      end
      return len;
   endfunction

   function automatic logic [ByteW-1:0] lead_mask(seq_len_type len);
      logic [ByteW-1:0] m;
      case (len)
         Len2:    m = 8'h1F;
         Len3:    m = 8'h0F;
         default: m = 8'h07;
      endcase
      return m;
   endfunction

   function automatic logic is_hidden(cp_type cp);
      return (cp >= ZwspLo && cp <= ZwspHi) || cp == Bom ||
             (cp >= BidiLo && cp <= BidiHi) ||
             (cp >= IsoLo && cp <= IsoHi) ||
             cp == HangFill || cp == ChoFill || cp == JungFill ||
             cp == HalfFill || cp == SoftHyph || cp == Cgj ||
             cp == ArabMark || cp == MongSep;
   endfunction

endpackage

// ----- design/icd_front.sv -----
// ----------------------------------------------------------------------------
// icd_front
// Input side: takes text bytes while the queue has room and tags each one
// with its sequence length and continuation flag.
// ----------------------------------------------------------------------------
module icd_front (
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [icd_pkg::DataW-1:0]    req_tdata,   // [7:0] text_byte
   input  logic                         req_tlast,   // end_of_text
   input  logic                         q_ready,
   output logic                         push,
   output icd_pkg::item_type            push_item
);

   // Accept whenever the queue can take the item
   assign req_tready = q_ready;
   assign push       = req_tvalid && q_ready;

   // Classify the byte
   always_comb begin
      push_item.sym.data = req_tdata[icd_pkg::ByteW-1:0];
      push_item.sym.len  = icd_pkg::lead_length(req_tdata[icd_pkg::ByteW-1:0]);
      push_item.sym.cont = (req_tdata[7:6] == 2'b10);
      push_item.last     = req_tlast;
   end

endmodule

// ----- design/icd_queue.sv -----
// ----------------------------------------------------------------------------
// icd_queue
// Two-entry item queue between the classifier and the scan engine.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module icd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  icd_pkg::item_type   push_item,
   output logic                q_ready,
   input  logic                pop,
   output logic                q_valid,
   output icd_pkg::item_type   pop_item
);

   icd_pkg::item_type store_ff [icd_pkg::QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_ready  = (count_ff != 2'(icd_pkg::QueueDepth));
   assign q_valid  = (count_ff != 2'd0);
   assign pop_item = store_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/icd_back.sv -----
// ----------------------------------------------------------------------------
// icd_back
// Scan engine: appends each byte to the pending window, decodes every
// sequence that is complete, matches the code point list and drives the
// result register on the final byte of a text.
// ----------------------------------------------------------------------------
module icd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  icd_pkg::item_type            pop_item,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [icd_pkg::DataW-1:0]    rsp_tdata    // [0] spoof_found
);

   icd_pkg::sym_type pend_ff [icd_pkg::PendDepth];
   icd_pkg::sym_type pend_in [icd_pkg::PendDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic       found_ff, found_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_flag_ff, rsp_flag_in;

   icd_pkg::sym_type     win [icd_pkg::WinDepth];
   logic [2:0]           n;
   logic [3:0]           complete;
   logic [3:0]           hid;
   icd_pkg::seq_len_type adv [4];
   icd_pkg::cp_type      acc;
   logic                 bad;
   logic [2:0]           p;
   logic [2:0]           rem;
   logic                 go;
   logic                 hit;
   logic                 final_item;
   logic                 out_free;

   assign final_item = pop_item.last;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = q_valid && (!final_item || out_free);

   // Build the window: pending bytes, the new byte, zero padding
   always_comb begin
      for (int i = 0; i < icd_pkg::WinDepth; i++) begin
         win[i] = '0;
         if (i < icd_pkg::PendDepth && 2'(i) < cnt_ff) begin
            win[i] = pend_ff[i];
         end else if (i < 4 && 2'(i) == cnt_ff) begin
            win[i] = pop_item.sym;
         end
      end
      n = {1'b0, cnt_ff} + 3'd1;
   end

   // Decode a sequence at every start position in parallel
   always_comb begin
      for (int s = 0; s < 4; s++) begin
         complete[s] = ({1'b0, 3'(s)} + {1'b0, win[s].len}) <= {1'b0, n};
         acc = icd_pkg::CpW'(win[s].data & icd_pkg::lead_mask(win[s].len));
         bad = 1'b0;
         for (int k = 1; k < 4; k++) begin
            if (3'(k) < win[s].len && !bad) begin
               if (win[s + k].cont) begin
                  acc = {acc[icd_pkg::CpW-7:0], win[s + k].data[5:0]};
               end else begin
                  bad = 1'b1;
               end
            end
         end
         hid[s] = icd_pkg::is_hidden(acc);
         adv[s] = bad ? icd_pkg::LenOne : win[s].len;
      end
   end

   // Walk the window: skip, stop on a partial sequence, or consume
   always_comb begin
      p   = 3'd0;
      go  = 1'b1;
      hit = 1'b0;
      for (int step = 0; step < 4; step++) begin
         if (go && p < n) begin
            if (win[p].len == icd_pkg::LenSkip) begin
               p = p + 3'd1;
            end else if (!complete[p[1:0]]) begin
               if (final_item) begin
                  p = p + 3'd1;
               end else begin
                  go = 1'b0;
               end
            end else begin
               hit = hit | hid[p[1:0]];
               p   = p + adv[p[1:0]];
            end
         end
      end
      rem = n - p;
   end

   // Next state: shift the leftover bytes to the front, clear on end of text
   always_comb begin
      for (int i = 0; i < icd_pkg::PendDepth; i++) begin
         pend_in[i] = '0;
         if (3'(i) < rem && !final_item) begin
            pend_in[i] = win[p + 3'(i)];
         end
      end
      cnt_in   = final_item ? 2'd0 : rem[1:0];
      found_in = final_item ? 1'b0 : (found_ff | hit);

      rsp_valid_in = rsp_valid_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (pop && final_item) begin
         rsp_valid_in = 1'b1;
         rsp_flag_in  = found_ff | hit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 2'd0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cnt_ff   <= cnt_in;
            found_ff <= found_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold pending bytes and the result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < icd_pkg::PendDepth; i++) begin
            pend_ff[i] <= pend_in[i];
         end
      end
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(icd_pkg::DataW-1)'(0), rsp_flag_ff};

endmodule

// ----- design/invisible_codepoint_detector.sv -----
// ----------------------------------------------------------------------------
// invisible_codepoint_detector
// Scans a UTF-8 text and flags invisible or direction-changing code points.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one text byte per item in req_tdata[7:0], req_tlast on the
//   final byte of the text. rsp channel: one item per text, given for the
//   final byte; rsp_tdata[0] is 1 when a listed code point was decoded.
//   Throughput: one byte per cycle unless a final byte waits for the output
//   register. The classifier writes a two-entry queue, the scan engine
//   drains it one byte per cycle, decoding the whole four-byte window combinationally.
//   Path: the final byte is registered in the queue, and its flag then in
//   the output register that drives rsp_tvalid.
//   Stall: a waiting result sits in the output register; bytes that are not
//   final keep flowing. A final byte waits in the queue until the output
//   register is free, and the queue then fills and drops req_tready.
//   Reset: synchronous, active high; clears the queue, the pending window,
//   the match flag and any undelivered result. A text always starts fresh
//   after its final byte.
// ----------------------------------------------------------------------------
module invisible_codepoint_detector (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [icd_pkg::DataW-1:0]    req_tdata,   // [7:0] text_byte
   input  logic                         req_tlast,   // end_of_text
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [icd_pkg::DataW-1:0]    rsp_tdata    // [0] spoof_found, [7:1] zero
);

   logic              q_ready;
   logic              push;
   logic              q_valid;
   logic              pop;
   icd_pkg::item_type push_item;
   icd_pkg::item_type pop_item;

   icd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_ready    (q_ready),
      .push       (push),
      .push_item  (push_item)
   );

   icd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .q_ready   (q_ready),
      .pop       (pop),
      .q_valid   (q_valid),
      .pop_item  (pop_item)
   );

   icd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- design/icd_checker.sv -----
// ----------------------------------------------------------------------------
// icd_checker
// Port-level checks of the invisible code point detector, bound to the top.
// ----------------------------------------------------------------------------
module icd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [icd_pkg::DataW-1:0]    rsp_tdata
);

   // Reset drops any undelivered result
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result still offered after reset");

   // Reset empties the queue, so the input side is open
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Only the flag bit may be set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[icd_pkg::DataW-1:1] == '0)
      else $error("padding bits of result not zero");

endmodule

bind invisible_codepoint_detector icd_checker u_icd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for invisible_codepoint_detector. Texts are streamed one
// byte per item on the req channel: a directed set of corner cases first,
// then random texts built from ASCII runs, UTF-8 sequences of listed and
// unlisted code points, broken and truncated sequences and raw noise. A
// scan model in the bench predicts the flag for each text; every rsp item is
// checked against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomBytes   = 1250;
   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned DrainCycles   = 20;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         drain;   // hold this item until every flag has come back
   } text_item_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [icd_pkg::DataW-1:0]   req_tdata  = '0;   // [7:0] text_byte
   logic                        req_tlast  = 1'b0; // end_of_text
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [icd_pkg::DataW-1:0]   rsp_tdata;         // [0] spoof_found

   text_item_type       tx_byte_q[$];
   logic                expected_flag_q[$];
   logic [7:0]          text_buf[$];

   // scan model state
   logic [7:0]          held_bytes [3];
   int unsigned         held_count;
   logic                text_has_hidden;

   int unsigned         error_count;
   int unsigned         cycle_count;
   int unsigned         quiet_cycles;
   logic                calm_window;

   invisible_codepoint_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // no idling on either side inside this stretch
   assign calm_window = (cycle_count >= 700) && (cycle_count < 1100);

   function automatic int unsigned seq_bytes(logic [7:0] b);
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
   endfunction

   function automatic logic is_listed_cp(icd_pkg::cp_type cp);
      return cp inside {[icd_pkg::ZwspLo:icd_pkg::ZwspHi], icd_pkg::Bom,
                        [icd_pkg::BidiLo:icd_pkg::BidiHi],
                        [icd_pkg::IsoLo:icd_pkg::IsoHi],
                        icd_pkg::HangFill, icd_pkg::ChoFill, icd_pkg::JungFill,
                        icd_pkg::HalfFill, icd_pkg::SoftHyph, icd_pkg::Cgj,
                        icd_pkg::ArabMark, icd_pkg::MongSep};
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   // Advance the scan model by one accepted text byte
   task automatic predict_scan(input logic [7:0] b, input logic last);
      logic [7:0]      win [4];
      int unsigned     fill, need, adv, i;
      icd_pkg::cp_type cp;
      logic            held;
      for (i = 0; i < 4; i++) win[i] = 8'h00;
      for (i = 0; i < held_count; i++) win[i] = held_bytes[i];
      win[held_count] = b;
      fill = held_count + 1;
      held = 1'b0;
      while (fill > 0 && !held) begin
         need = seq_bytes(win[0]);
         adv  = 1;
         if (need > fill && !last) begin
            // wait for the rest of the sequence
            held = 1'b1;
         end else if (need != 0 && need <= fill) begin
            cp  = icd_pkg::cp_type'(win[0] &
                     (need == 2 ? 8'h1F : (need == 3 ? 8'h0F : 8'h07)));
            adv = need;
            for (i = 1; i < need; i++) begin
               // a bad continuation ends the value early; restart after the lead
               if (win[i][7:6] != 2'b10) begin
                  adv = 1;
                  break;
               end
               cp = (cp << 6) | icd_pkg::cp_type'(win[i][5:0]);
            end
            if (is_listed_cp(cp)) text_has_hidden = 1'b1;
         end
         if (!held) begin
            for (i = 0; i + adv < 4; i++) win[i] = win[i + adv];
            fill = fill - adv;
         end
      end
      if (last) begin
         expected_flag_q.push_back(text_has_hidden);
         text_has_hidden = 1'b0;
         held_count      = 0;
         for (i = 0; i < 3; i++) held_bytes[i] = 8'h00;
      end else begin
         for (i = 0; i < 3; i++) held_bytes[i] = (i < fill) ? win[i] : 8'h00;
         held_count = fill;
      end
   endtask

   // Stimulus helpers: build a text in text_buf, then hand it to the driver
   task automatic flush_text(input bit drain);
      text_item_type it;
      for (int i = 0; i < text_buf.size(); i++) begin
         it.data  = text_buf[i];
         it.last  = (i == text_buf.size() - 1);
         it.drain = drain && (i == 0);
         tx_byte_q.push_back(it);
      end
      text_buf.delete();
   endtask

   task automatic put_cp(input icd_pkg::cp_type cp, input int unsigned nb);
      logic [7:0] prefix, mask;
      if (nb == 1) begin
         text_buf.push_back(cp[7:0]);
      end else begin
         prefix = (nb == 2) ? 8'hC0 : ((nb == 3) ? 8'hE0 : 8'hF0);
         mask   = (nb == 2) ? 8'h1F : ((nb == 3) ? 8'h0F : 8'h07);
         text_buf.push_back(prefix | (8'(cp >> (6 * (nb - 1))) & mask));
         for (int i = nb - 2; i >= 0; i--)
            text_buf.push_back(8'h80 | (8'(cp >> (6 * i)) & 8'h3F));
      end
   endtask

   function automatic int unsigned min_bytes(icd_pkg::cp_type cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   function automatic icd_pkg::cp_type pick_hidden_cp();
      case ($urandom_range(11))
         0:  return icd_pkg::ZwspLo + icd_pkg::cp_type'($urandom_range(2));
         1:  return icd_pkg::Bom;
         2:  return icd_pkg::BidiLo + icd_pkg::cp_type'($urandom_range(4));
         3:  return icd_pkg::IsoLo + icd_pkg::cp_type'($urandom_range(3));
         4:  return icd_pkg::HangFill;
         5:  return icd_pkg::ChoFill;
         6:  return icd_pkg::JungFill;
         7:  return icd_pkg::HalfFill;
         8:  return icd_pkg::SoftHyph;
         9:  return icd_pkg::Cgj;
         10: return icd_pkg::ArabMark;
         default: return icd_pkg::MongSep;
      endcase
   endfunction

   // Encode a code point, sometimes in an overlong form
   task automatic put_encoded(input icd_pkg::cp_type cp);
      int unsigned nb;
      nb = min_bytes(cp);
      if (nb < 4 && $urandom_range(99) < 20) nb = $urandom_range(4, (nb < 2) ? 2 : nb);
      put_cp(cp, nb);
   endtask

   // Lead byte plus fewer continuation bytes than it announces
   task automatic put_partial(output int unsigned nb);
      int unsigned k;
      nb = $urandom_range(2, 4);
      case (nb)
         2:       text_buf.push_back(8'hC0 | 8'($urandom_range(31)));
         3:       text_buf.push_back(8'hE0 | 8'($urandom_range(15)));
         default: text_buf.push_back(8'hF0 | 8'($urandom_range(7)));
      endcase
      k = $urandom_range(nb - 2);
      repeat (k) text_buf.push_back(8'h80 | 8'($urandom_range(63)));
   endtask

   task automatic build_random_text(output int unsigned nbytes);
      int unsigned     segs, nb, pick;
      bit              allow_hidden;
      icd_pkg::cp_type cp;
      segs         = $urandom_range(1, 8);
      allow_hidden = ($urandom_range(99) < 60);
      repeat (segs) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(8'h7F)));
         end else if (pick < 50 && allow_hidden) begin
            put_encoded(pick_hidden_cp());
         end else if (pick < 72) begin
            // unlisted code points, often right beside a listed one
            if ($urandom_range(99) < 35)
               cp = pick_hidden_cp() + ($urandom_range(1) ? icd_pkg::cp_type'(1)
                                                          : -icd_pkg::cp_type'(1));
            else if ($urandom_range(99) < 15)
               cp = icd_pkg::cp_type'($urandom_range(21'h1FFFFF));
            else
               cp = icd_pkg::cp_type'($urandom_range(21'h80, 21'h10FFFF));
            if (!allow_hidden && is_listed_cp(cp)) cp = 21'h41;
            put_cp(cp, (cp > 21'h10FFFF) ? 4 : min_bytes(cp));
         end else if (pick < 88) begin
            // broken sequence: lead, short run of continuations, then a non-continuation
            put_partial(nb);
            if ($urandom_range(1))
               text_buf.push_back(8'($urandom_range(8'h7F)));
            else
               text_buf.push_back(8'($urandom_range(8'hC0, 8'hFF)));
         end else begin
            text_buf.push_back(8'($urandom_range(8'hFF)));
         end
      end
      // sometimes cut the text in the middle of a sequence
      if ($urandom_range(99) < 15) put_partial(nb);
      nbytes = text_buf.size();
   endtask

   // Drive text bytes; hold each one until it is taken
   always @(posedge clock) begin : feed_bytes
      logic rest;
      rest = !calm_window && ($urandom_range(99) < 25);
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (tx_byte_q.size() != 0 && !rest &&
             !(tx_byte_q[0].drain && (req_tvalid || expected_flag_q.size() != 0))) begin
            req_tvalid <= 1'b1;
            req_tdata  <= icd_pkg::DataW'(tx_byte_q[0].data);
            req_tlast  <= tx_byte_q[0].last;
            tx_byte_q.delete(0);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the result side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm_window || ($urandom_range(99) >= 25);
      end
   end

   // Predict on accepted bytes, check accepted flags
   always @(posedge clock) begin : watch_flags
      logic want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_flag_q.size() == 0) begin
               report_mismatch($sformatf("flag %0b with no text pending", rsp_tdata[0]));
            end else begin
               want = expected_flag_q.pop_front();
               if (rsp_tdata[0] !== want)
                  report_mismatch($sformatf("spoof_found %0b, want %0b", rsp_tdata[0], want));
            end
         end
         if (req_tvalid && req_tready) predict_scan(req_tdata[7:0], req_tlast);
      end
   end

   // Count cycles; end the run after too long without any handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_texts
      int unsigned total, nbytes, text_no;
      error_count     = 0;
      cycle_count     = 0;
      quiet_cycles    = 0;
      held_count      = 0;
      text_has_hidden = 1'b0;
      for (int i = 0; i < 3; i++) held_bytes[i] = 8'h00;

      // directed texts: byte extremes, listed values, broken and cut sequences
      text_buf = {8'h00};                      flush_text(0);
      text_buf = {8'hFF};                      flush_text(0);
      text_buf = {8'hE2, 8'h80, 8'h8B};        flush_text(0);  // zero width space
      text_buf = {8'hC2, 8'hAD};               flush_text(0);  // soft hyphen
      text_buf = {8'hEF, 8'hBB, 8'hBF};        flush_text(0);  // byte order mark
      // bad continuation: the two gathered bytes still form a listed value
      text_buf = {8'hE2, 8'hAD, 8'h41};        flush_text(1);
      // four-byte lead cut by the end, the bytes after it decode on their own
      text_buf = {8'hF0, 8'hC2, 8'hAD};        flush_text(0);
      // overlong form of a listed value
      text_buf = {8'hE0, 8'h82, 8'hAD, 8'h7F}; flush_text(0);
      // surrogate, then a lead cut by the end
      text_buf = {8'hED, 8'hA0, 8'h80, 8'hE2}; flush_text(0);
      text_buf = {8'hF7, 8'hBF, 8'hBF, 8'hBF}; flush_text(0);

      // random texts
      total   = 0;
      text_no = 0;
      while (total < RandomBytes) begin
         build_random_text(nbytes);
         if (nbytes == 0) begin
            text_buf.push_back(8'($urandom_range(8'h7F)));
            nbytes = 1;
         end
         total += nbytes;
         flush_text(text_no % 25 == 0);
         text_no++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait for the last byte to go, then for every flag, then a short drain
      while (tx_byte_q.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_flag_q.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/icd_pkg.sv
design/icd_front.sv
design/icd_queue.sv
design/icd_back.sv
design/invisible_codepoint_detector.sv
design/icd_checker.sv
tb/tb_top.sv
